// ===== src/ttcc_pkg.sv =====
// Shared constants, types and command codes of the two-tube coincidence counter.
`default_nettype none
package ttcc_pkg;

  localparam int unsigned COUNT_WIDTH  = 32;
  localparam int unsigned TIME_WIDTH   = 32;
  localparam int unsigned WINDOW_WIDTH = 20;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QUEUE_AW     = $clog2(QUEUE_DEPTH);

  localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = WINDOW_WIDTH'(1000);

  typedef logic [1:0]             func_t;
  typedef logic [TIME_WIDTH-1:0]  stamp_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [WINDOW_WIDTH-1:0] window_t;

  localparam func_t FUNC_TUBE1    = 2'd0;
  localparam func_t FUNC_TUBE2    = 2'd1;
  localparam func_t FUNC_BOUNDARY = 2'd2;
  localparam func_t FUNC_DAY      = 2'd3;

  typedef enum logic [1:0] {
    KIND_TUBE1,
    KIND_TUBE2,
    KIND_BOUNDARY,
    KIND_DAY
  } kind_t;

  typedef struct packed {
    kind_t  kind;
    stamp_t stamp;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage
`default_nettype wire

// ===== src/ttcc_if.sv =====
// Event and result channel interfaces of the coincidence counter.
`default_nettype none
interface ttcc_in_if;
  logic                  valid;
  logic                  ready;
  ttcc_pkg::func_t       func;
  ttcc_pkg::stamp_t      timestamp_us;

  modport source (output valid, output func, output timestamp_us, input ready);
  modport sink   (input valid, input func, input timestamp_us, output ready);
endinterface

interface ttcc_out_if;
  logic                  valid;
  logic                  ready;
  ttcc_pkg::count_t      interval_tube1_count;
  ttcc_pkg::count_t      interval_tube2_count;
  ttcc_pkg::count_t      interval_coincidence_count;
  ttcc_pkg::count_t      daily_tube1_count;
  ttcc_pkg::count_t      daily_tube2_count;
  ttcc_pkg::count_t      daily_coincidence_count;
  logic                  coincidence_found;
  logic                  record_valid;
  logic                  syncing;

  modport source (
    output valid, input ready,
    output interval_tube1_count, output interval_tube2_count,
    output interval_coincidence_count, output daily_tube1_count,
    output daily_tube2_count, output daily_coincidence_count,
    output coincidence_found, output record_valid, output syncing
  );
  modport sink (
    input valid, output ready,
    input interval_tube1_count, input interval_tube2_count,
    input interval_coincidence_count, input daily_tube1_count,
    input daily_tube2_count, input daily_coincidence_count,
    input coincidence_found, input record_valid, input syncing
  );
endinterface
`default_nettype wire

// ===== src/two_tube_coincidence_counter.sv =====
// Top level of the two-tube coincidence counter.
//
// events carries one timestamped word per handshake: func selects a tube 1
// pulse, a tube 2 pulse, an interval boundary or a day change. results
// returns exactly one word per event: the interval and daily counts after
// the event's increments (before any clear it causes), the coincidence flag,
// the closed-record flag and the syncing flag.
// cfg_write/cfg_data load the coincidence window in microseconds; write it
// only while no event is in flight.
// Throughput is one event per cycle while results.ready stays high. From the
// accepting edge, the front end's classify register moves the word into the
// queue, and the back end reads the queue head directly into its result
// register. The back end updates the counters and stored pulse times on the
// same edge that loads its result register, which sets that rate.
// Reset clears all counters and stored times, sets the window to 1000 us and
// enters the syncing phase until the first interval boundary.
// When the receiver stalls, the result word holds, the four-entry queue
// fills, then the front register, and only then does events.ready drop.
`default_nettype none
module two_tube_coincidence_counter (
  input  wire logic              clk,
  input  wire logic              rst,
  ttcc_in_if.sink                events,
  ttcc_out_if.source             results,
  input  wire logic              cfg_write,
  input  wire ttcc_pkg::window_t cfg_data
);

  ttcc_pkg::qstat_t qstat;
  ttcc_pkg::cmd_t   push_cmd;
  ttcc_pkg::cmd_t   pop_cmd;
  logic             push_valid;
  logic             pop;

  ttcc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .events    (events),
    .qstat     (qstat),
    .cmd_valid (push_valid),
    .cmd       (push_cmd)
  );

  ttcc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .pop_cmd    (pop_cmd),
    .qstat      (qstat)
  );

  ttcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .qstat     (qstat),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .results   (results)
  );

endmodule
`default_nettype wire

// ===== src/ttcc_front.sv =====
// Front end: accepts events, classifies them and hands commands to the queue.
`default_nettype none
module ttcc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  ttcc_in_if.sink              events,
  input  wire ttcc_pkg::qstat_t qstat,
  output logic                 cmd_valid,
  output ttcc_pkg::cmd_t       cmd
);

  logic           stage_valid;
  ttcc_pkg::cmd_t stage_cmd;
  ttcc_pkg::cmd_t decoded;

  // Take a new word when the stage is empty or drains into the queue this cycle.
  assign events.ready = !stage_valid || !qstat.full;
  assign cmd_valid    = stage_valid;
  assign cmd          = stage_cmd;

  always_comb begin
    decoded.stamp = events.timestamp_us;
    unique case (events.func)
      ttcc_pkg::FUNC_TUBE1:    decoded.kind = ttcc_pkg::KIND_TUBE1;
      ttcc_pkg::FUNC_TUBE2:    decoded.kind = ttcc_pkg::KIND_TUBE2;
      ttcc_pkg::FUNC_BOUNDARY: decoded.kind = ttcc_pkg::KIND_BOUNDARY;
      ttcc_pkg::FUNC_DAY:      decoded.kind = ttcc_pkg::KIND_DAY;
      default:                 decoded.kind = ttcc_pkg::KIND_DAY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (events.ready) begin
      stage_valid <= events.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (events.valid && events.ready) begin
      stage_cmd <= decoded;
    end
  end

endmodule
`default_nettype wire

// ===== src/ttcc_queue.sv =====
// Short command queue between the front end and the counting back end.
`default_nettype none
module ttcc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  input  wire ttcc_pkg::cmd_t  push_cmd,
  input  wire logic            pop,
  output ttcc_pkg::cmd_t       pop_cmd,
  output ttcc_pkg::qstat_t     qstat
);

  localparam logic [ttcc_pkg::QUEUE_AW:0]   DEPTH_CNT =
    (ttcc_pkg::QUEUE_AW+1)'(ttcc_pkg::QUEUE_DEPTH);
  localparam logic [ttcc_pkg::QUEUE_AW-1:0] LAST_PTR  =
    ttcc_pkg::QUEUE_AW'(ttcc_pkg::QUEUE_DEPTH - 1);

  ttcc_pkg::cmd_t                entries [ttcc_pkg::QUEUE_DEPTH];
  logic [ttcc_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [ttcc_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [ttcc_pkg::QUEUE_AW:0]   count;
  logic                          push_ok;
  logic                          pop_ok;

  assign qstat.full  = (count == DEPTH_CNT);
  assign qstat.empty = (count == '0);
  assign push_ok     = push_valid && !qstat.full;
  assign pop_ok      = pop && !qstat.empty;
  assign pop_cmd     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push_ok, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("queue count above depth");

  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    push_valid && qstat.full && !pop |=> qstat.full)
    else $error("push into full queue changed fill level");

endmodule
`default_nettype wire

// ===== src/ttcc_back.sv =====
// Back end: coincidence test, saturating counters and the result register.
`default_nettype none
module ttcc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire ttcc_pkg::window_t cfg_data,
  input  wire ttcc_pkg::qstat_t  qstat,
  input  wire ttcc_pkg::cmd_t    pop_cmd,
  output logic                   pop,
  ttcc_out_if.source             results
);

  function automatic ttcc_pkg::count_t sat_inc(input ttcc_pkg::count_t v);
    return (&v) ? v : v + ttcc_pkg::count_t'(1);
  endfunction

  ttcc_pkg::window_t window;
  ttcc_pkg::stamp_t  last_tube1_time;
  ttcc_pkg::stamp_t  last_tube2_time;
  ttcc_pkg::stamp_t  last_coincidence_time;
  ttcc_pkg::count_t  interval_tube1;
  ttcc_pkg::count_t  interval_tube2;
  ttcc_pkg::count_t  interval_coincidences;
  ttcc_pkg::count_t  daily_tube1;
  ttcc_pkg::count_t  daily_tube2;
  ttcc_pkg::count_t  daily_coincidences;
  logic              waiting_sync;

  logic              is_tube1;
  logic              is_tube2;
  logic              is_pulse;
  logic              is_boundary;
  logic              is_day;
  ttcc_pkg::stamp_t  other_time;
  ttcc_pkg::stamp_t  gap_other;
  ttcc_pkg::stamp_t  gap_coin;
  ttcc_pkg::stamp_t  window_wide;
  logic              hit;
  ttcc_pkg::count_t  interval_tube1_next;
  ttcc_pkg::count_t  interval_tube2_next;
  ttcc_pkg::count_t  interval_coincidences_next;
  ttcc_pkg::count_t  daily_tube1_next;
  ttcc_pkg::count_t  daily_tube2_next;
  ttcc_pkg::count_t  daily_coincidences_next;

  // Advance when a command waits and the result register is free or being taken.
  assign pop = !qstat.empty && (!results.valid || results.ready);

  assign is_tube1    = (pop_cmd.kind == ttcc_pkg::KIND_TUBE1);
  assign is_tube2    = (pop_cmd.kind == ttcc_pkg::KIND_TUBE2);
  assign is_boundary = (pop_cmd.kind == ttcc_pkg::KIND_BOUNDARY);
  assign is_day      = (pop_cmd.kind == ttcc_pkg::KIND_DAY);
  assign is_pulse    = is_tube1 || is_tube2;

  // Time differences wrap modulo the timestamp width.
  assign other_time  = is_tube1 ? last_tube2_time : last_tube1_time;
  assign gap_other   = pop_cmd.stamp - other_time;
  assign gap_coin    = pop_cmd.stamp - last_coincidence_time;
  assign window_wide = ttcc_pkg::stamp_t'(window);
  assign hit         = is_pulse && (gap_other <= window_wide) && (gap_coin > window_wide);

  assign interval_tube1_next        = is_tube1 ? sat_inc(interval_tube1) : interval_tube1;
  assign interval_tube2_next        = is_tube2 ? sat_inc(interval_tube2) : interval_tube2;
  assign interval_coincidences_next = hit ? sat_inc(interval_coincidences)
                                          : interval_coincidences;
  assign daily_tube1_next           = is_tube1 ? sat_inc(daily_tube1) : daily_tube1;
  assign daily_tube2_next           = is_tube2 ? sat_inc(daily_tube2) : daily_tube2;
  assign daily_coincidences_next    = hit ? sat_inc(daily_coincidences) : daily_coincidences;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= ttcc_pkg::WINDOW_RESET;
    end else if (cfg_write) begin
      window <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid         <= 1'b0;
      last_tube1_time       <= '0;
      last_tube2_time       <= '0;
      last_coincidence_time <= '0;
      interval_tube1        <= '0;
      interval_tube2        <= '0;
      interval_coincidences <= '0;
      daily_tube1           <= '0;
      daily_tube2           <= '0;
      daily_coincidences    <= '0;
      waiting_sync          <= 1'b1;
    end else begin
      if (pop) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      if (pop) begin
        if (is_tube1) begin
          last_tube1_time <= pop_cmd.stamp;
        end
        if (is_tube2) begin
          last_tube2_time <= pop_cmd.stamp;
        end
        if (hit) begin
          last_coincidence_time <= pop_cmd.stamp;
        end
        // Boundaries clear the interval counts after they are reported.
        interval_tube1        <= is_boundary ? '0 : interval_tube1_next;
        interval_tube2        <= is_boundary ? '0 : interval_tube2_next;
        interval_coincidences <= is_boundary ? '0 : interval_coincidences_next;
        daily_tube1           <= is_day ? '0 : daily_tube1_next;
        daily_tube2           <= is_day ? '0 : daily_tube2_next;
        daily_coincidences    <= is_day ? '0 : daily_coincidences_next;
        if (is_boundary) begin
          waiting_sync <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      results.interval_tube1_count       <= interval_tube1_next;
      results.interval_tube2_count       <= interval_tube2_next;
      results.interval_coincidence_count <= interval_coincidences_next;
      results.daily_tube1_count          <= daily_tube1_next;
      results.daily_tube2_count          <= daily_tube2_next;
      results.daily_coincidence_count    <= daily_coincidences_next;
      results.coincidence_found          <= hit;
      results.record_valid               <= is_boundary && !waiting_sync;
      results.syncing                    <= waiting_sync && !is_boundary;
    end
  end

  a_record_after_sync: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.record_valid |-> !results.syncing)
    else $error("closed record reported while syncing");

  a_sync_sticks: assert property (@(posedge clk) disable iff (rst)
    !waiting_sync |=> !waiting_sync)
    else $error("syncing phase re-entered without reset");

  a_no_coin_on_edge: assert property (@(posedge clk) disable iff (rst)
    pop && !is_pulse |=> !results.coincidence_found)
    else $error("coincidence flagged on a non-pulse event");

  a_coin_counted: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.coincidence_found |-> results.daily_coincidence_count != '0)
    else $error("coincidence flagged with zero daily count");

endmodule
`default_nettype wire
